// ===== src/rccb_pkg.sv =====
package rccb_pkg;

  localparam int unsigned MaxEntries = 65536;
  localparam int unsigned SlotW = $clog2(MaxEntries);
  localparam int unsigned CountW = SlotW + 1;
  localparam int unsigned EpochW = 8;
  localparam int unsigned RemW = CountW + 1;

  localparam logic [63:0] SeedX = 64'd123456789;
  localparam logic [63:0] SeedY = 64'd362436069;
  localparam logic [63:0] SeedZ = 64'd521288629;

  localparam logic [15:0] SlotMask = 16'hffff;

  localparam logic [1:0] RegEntryCount = 2'd0;

  localparam logic FuncBegin = 1'b0;
  localparam logic FuncNext = 1'b1;

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] z;
  } gen_state_t;

  function automatic gen_state_t gen_step(gen_state_t s);
    logic [63:0] t;
    gen_state_t r;
    t = s.x ^ (s.x << 16);
    t = t ^ (t >> 5);
    t = t ^ (t << 1);
    r.x = s.y;
    r.y = s.z;
    r.z = t ^ s.y ^ s.z;
    return r;
  endfunction

endpackage

// ===== src/rccb_mod.sv =====
module rccb_mod (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [63:0]                   dividend_i,
  input  logic [rccb_pkg::CountW-1:0]   divisor_i,
  output logic                          done_o,
  output logic [rccb_pkg::SlotW-1:0]    rem_o
);
  import rccb_pkg::*;

  logic [6:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [63:0] dvd_q, dvd_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic [RemW-1:0] trial;
  logic [RemW:0] diff;

  always_comb begin
    trial = {rem_q[RemW-2:0], dvd_q[63]};
    diff = {1'b0, trial} - {2'b00, divisor_i};
    cnt_d = cnt_q;
    busy_d = busy_q;
    dvd_d = dvd_q;
    rem_d = rem_q;
    done_o = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = 7'd0;
      dvd_d = dividend_i;
      rem_d = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[62:0], 1'b0};
      rem_d = diff[RemW] ? trial : diff[RemW-1:0];
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
      end
    end
    if (busy_q && !busy_d) begin
      done_o = 1'b1;
    end
  end

  assign rem_o = rem_d[SlotW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

endmodule

// ===== src/rccb_map.sv =====
module rccb_map (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [rccb_pkg::SlotW-1:0] waddr_i,
  input  logic [rccb_pkg::EpochW-1:0] wdata_i,
  input  logic [rccb_pkg::SlotW-1:0] raddr_i,
  output logic [rccb_pkg::EpochW-1:0] rdata_o
);
  import rccb_pkg::*;

  logic [EpochW-1:0] mem_q [MaxEntries];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/random_cyclic_chain_builder.sv =====
// Channel | Signals                               | Direction
// in      | in_valid_i, in_ready_o, func_i, ...   | into block
// out     | out_valid_o, out_ready_i, from/to/last| out of block
// cfg     | psel, penable, pwrite, paddr, pwdata  | APB register port
// A begin transfer runs the warmup, one generator step a cycle, and then the
// bit-serial remainder unit. A next transfer runs the remainder unit and then
// probes the map memory, stepping past each visited slot until a free one.
// The map is marked with an 8-bit epoch; every 255th begin sweeps all 65536
// map entries, and reset starts with that sweep before any transfer.
// A result waits in an output register and stalls only the next transfer.
module random_cyclic_chain_builder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic [15:0]                   warmup_steps_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [15:0]                   from_slot_o,
  output logic [15:0]                   to_slot_o,
  output logic                          last_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [1:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import rccb_pkg::*;

  typedef enum logic [3:0] {
    StClear, StIdle, StWarm, StDraw, StDiv, StProbe, StCheck, StEmit, StSweep
  } state_e;

  state_e state_q;
  gen_state_t gen_q;
  logic [16:0] entry_count_q;
  logic [CountW-1:0] total_q;
  logic [SlotW-1:0] head_q, cur_q, probe_q;
  logic [CountW-1:0] filled_q;
  logic active_q, begin_q;
  logic [EpochW-1:0] epoch_q;
  logic [15:0] warm_q;
  logic [SlotW-1:0] sweep_q;
  logic out_valid_q;
  logic [15:0] from_q, to_q;
  logic last_q;

  logic div_start, div_done;
  logic [SlotW-1:0] div_rem;
  logic map_we;
  logic [SlotW-1:0] map_waddr, map_raddr;
  logic [EpochW-1:0] map_wdata, map_rdata;
  logic [CountW-1:0] eff_count;
  logic [CountW-1:0] probe_inc;
  gen_state_t gen_nx;

  assign pready = 1'b1;
  assign prdata = {15'd0, entry_count_q};
  assign in_ready_o = (state_q == StIdle) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign from_slot_o = from_q;
  assign to_slot_o = to_q;
  assign last_o = last_q;
  assign gen_nx = gen_step(gen_q);
  assign div_start = (state_q == StDraw);
  assign probe_inc = {1'b0, probe_q} + 1'b1;

  always_comb begin
    eff_count = entry_count_q[CountW-1:0];
    if (entry_count_q == 17'd0) begin
      eff_count = CountW'(1);
    end else if ({15'd0, entry_count_q} > 32'(MaxEntries)) begin
      eff_count = CountW'(MaxEntries);
    end
  end

  rccb_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (gen_q.z),
    .divisor_i  (total_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_comb begin
    map_we = 1'b0;
    map_waddr = probe_q;
    map_wdata = epoch_q;
    map_raddr = probe_q;
    if (state_q == StClear || state_q == StSweep) begin
      map_we = 1'b1;
      map_waddr = sweep_q;
      map_wdata = '0;
    end else if (state_q == StDiv && div_done) begin
      map_raddr = div_rem;
    end else if (state_q == StCheck && map_rdata == epoch_q) begin
      map_raddr = (probe_inc >= total_q) ? '0 : probe_inc[SlotW-1:0];
    end else if (state_q == StEmit) begin
      map_we = 1'b1;
    end
  end

  rccb_map u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      gen_q <= '{x: SeedX, y: SeedY, z: SeedZ};
      entry_count_q <= 17'h10000;
      total_q <= CountW'(1);
      head_q <= '0;
      cur_q <= '0;
      probe_q <= '0;
      filled_q <= '0;
      active_q <= 1'b0;
      begin_q <= 1'b0;
      epoch_q <= EpochW'(1);
      warm_q <= '0;
      sweep_q <= '0;
      out_valid_q <= 1'b0;
      from_q <= '0;
      to_q <= '0;
      last_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == RegEntryCount) begin
        entry_count_q <= pwdata[16:0];
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StClear, StSweep: begin
          sweep_q <= sweep_q + 1'b1;
          if (sweep_q == SlotW'(MaxEntries - 1)) begin
            state_q <= (state_q == StClear) ? StIdle : StWarm;
          end
        end
        StIdle: begin
          if (in_valid_i && in_ready_o) begin
            if (func_i == FuncBegin) begin
              total_q <= eff_count;
              warm_q <= warmup_steps_i;
              begin_q <= 1'b1;
              active_q <= 1'b1;
              filled_q <= CountW'(1);
              if (epoch_q == {EpochW{1'b1}}) begin
                epoch_q <= EpochW'(1);
                sweep_q <= '0;
                state_q <= StSweep;
              end else begin
                epoch_q <= epoch_q + 1'b1;
                state_q <= StWarm;
              end
            end else if (active_q) begin
              begin_q <= 1'b0;
              if (filled_q >= total_q) begin
                from_q <= cur_q;
                to_q <= head_q;
                last_q <= 1'b1;
                out_valid_q <= 1'b1;
                active_q <= 1'b0;
              end else begin
                gen_q <= gen_nx;
                state_q <= StDraw;
              end
            end
          end
        end
        StWarm: begin
          gen_q <= gen_nx;
          if (warm_q == 16'd0) begin
            state_q <= StDraw;
          end else begin
            warm_q <= warm_q - 1'b1;
          end
        end
        StDraw: begin
          state_q <= StDiv;
        end
        StDiv: begin
          if (div_done) begin
            probe_q <= div_rem;
            state_q <= begin_q ? StEmit : StProbe;
          end
        end
        StProbe: begin
          state_q <= StCheck;
        end
        StCheck: begin
          if (map_rdata == epoch_q) begin
            probe_q <= (probe_inc >= total_q) ? '0 : probe_inc[SlotW-1:0];
          end else begin
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (begin_q) begin
            head_q <= probe_q;
          end else begin
            from_q <= cur_q;
            to_q <= probe_q & SlotMask;
            last_q <= 1'b0;
            out_valid_q <= 1'b1;
            filled_q <= filled_q + 1'b1;
          end
          cur_q <= probe_q;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
